/* src/mm3_pkg.sv */
// Shared constants, command codes and controller/datapath interface types for the hash block.
package mm3_pkg;

   // Hash constants
   localparam logic [31:0] SCR_MUL_A = 32'hcc9e2d51;
   localparam logic [31:0] SCR_MUL_B = 32'h1b873593;
   localparam logic [31:0] ACC_ADD   = 32'he6546b64;
   localparam logic [31:0] FIN_MUL_A = 32'h85ebca6b;
   localparam logic [31:0] FIN_MUL_B = 32'hc2b2ae35;

   // Byte counts
   localparam logic [2:0] FULL_BYTES = 3'd4;

   // Datapath operation codes
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_SCR_A = 3'd1;
   localparam logic [2:0] OP_SCR_B = 3'd2;
   localparam logic [2:0] OP_MIX   = 3'd3;
   localparam logic [2:0] OP_FIN_A = 3'd4;
   localparam logic [2:0] OP_FIN_B = 3'd5;
   localparam logic [2:0] OP_FIN_C = 3'd6;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic [2:0] op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_item;
      logic out_blocked;
   } dp_status_type;

endpackage

/* src/mm3_ctrl.sv */
// Sequencing state machine: steps each word through scramble and mix, and a last word also through the finalizer.
module mm3_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mm3_pkg::dp_status_type dp_status,
   output mm3_pkg::dp_cmd_type    dp_cmd
);
   import mm3_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCR_A = 3'd1;
   localparam logic [2:0] ST_SCR_B = 3'd2;
   localparam logic [2:0] ST_MIX   = 3'd3;
   localparam logic [2:0] ST_FIN_A = 3'd4;
   localparam logic [2:0] ST_FIN_B = 3'd5;
   localparam logic [2:0] ST_FIN_C = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      dp_cmd.load = 1'b0;
      dp_cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_SCR_A;
            end
         end
         ST_SCR_A: begin
            dp_cmd.op = OP_SCR_A;
            state_in  = ST_SCR_B;
         end
         ST_SCR_B: begin
            dp_cmd.op = OP_SCR_B;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            dp_cmd.op = OP_MIX;
            state_in  = dp_status.last_item ? ST_FIN_A : ST_IDLE;
         end
         ST_FIN_A: begin
            dp_cmd.op = OP_FIN_A;
            state_in  = ST_FIN_B;
         end
         ST_FIN_B: begin
            dp_cmd.op = OP_FIN_B;
            state_in  = ST_FIN_C;
         end
         ST_FIN_C: begin
            // hold until the output register can take the hash
            dp_cmd.op = OP_FIN_C;
            if (!dp_status.out_blocked) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/mm3_datapath.sv */
// Hash datapath: word register, shared 32x32 multiplier, running hash, byte total, output register.
module mm3_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mm3_pkg::dp_cmd_type     dp_cmd,
   output mm3_pkg::dp_status_type  dp_status,
   input  logic [31:0]            req_data_word,
   input  logic [2:0]             req_byte_count,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_hash_value
);
   import mm3_pkg::*;

   logic [31:0] word_ff, word_in;
   logic [2:0]  add_ff, add_in;
   logic        last_ff, last_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_ff, out_in;

   logic [2:0]  sat_count;
   logic [2:0]  load_add;
   logic [31:0] load_mask;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_full;
   logic [31:0] prod;
   logic [31:0] mix_x, mix_rot, mix_val;
   logic [31:0] fin_x, fin_pre;
   logic        out_blocked;

   // Count saturation; non-last words always count as four bytes
   assign sat_count = (req_byte_count > FULL_BYTES) ? FULL_BYTES : req_byte_count;
   assign load_add  = req_last ? sat_count : FULL_BYTES;

   // Keep only the valid bytes of a short tail word
   always_comb begin
      case (load_add)
         3'd1:    load_mask = 32'h0000_00ff;
         3'd2:    load_mask = 32'h0000_ffff;
         3'd3:    load_mask = 32'h00ff_ffff;
         default: load_mask = 32'hffff_ffff;
      endcase
   end

   // Block mix: rotl13(h ^ k) * 5 + constant, *5 done as shift-add
   assign mix_x   = hash_ff ^ word_ff;
   assign mix_rot = {mix_x[18:0], mix_x[31:19]};
   assign mix_val = {mix_rot[29:0], 2'b00} + mix_rot + ACC_ADD;

   // Finalizer front: fold in length, xor-shift 16
   assign fin_x   = hash_ff ^ total_ff;
   assign fin_pre = fin_x ^ (fin_x >> 16);

   assign out_blocked = rsp_valid_ff && rsp_stall;

   // Shared multiplier operand select
   always_comb begin
      mul_a = word_ff;
      mul_b = SCR_MUL_A;
      case (dp_cmd.op)
         OP_SCR_A: begin
            mul_a = word_ff;
            mul_b = SCR_MUL_A;
         end
         OP_SCR_B: begin
            mul_a = {word_ff[16:0], word_ff[31:17]};
            mul_b = SCR_MUL_B;
         end
         OP_FIN_A: begin
            mul_a = fin_pre;
            mul_b = FIN_MUL_A;
         end
         OP_FIN_B: begin
            mul_a = word_ff ^ (word_ff >> 13);
            mul_b = FIN_MUL_B;
         end
         default: begin
            mul_a = word_ff;
            mul_b = SCR_MUL_A;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;
   assign prod      = prod_full[31:0];

   // Register updates per operation
   always_comb begin
      word_in      = word_ff;
      add_in       = add_ff;
      last_in      = last_ff;
      hash_in      = hash_ff;
      total_in     = total_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (dp_cmd.op)
         OP_SCR_A, OP_SCR_B, OP_FIN_A, OP_FIN_B: begin
            word_in = prod;
         end
         OP_MIX: begin
            if (add_ff == FULL_BYTES) begin
               hash_in = mix_val;
            end else if (add_ff != 3'd0) begin
               hash_in = mix_x;
            end
            total_in = total_ff + {29'd0, add_ff};
         end
         OP_FIN_C: begin
            if (!out_blocked) begin
               out_in       = word_ff ^ (word_ff >> 16);
               rsp_valid_in = 1'b1;
               hash_in      = 32'd0;
               total_in     = 32'd0;
            end
         end
         default: begin
         end
      endcase
      // new transaction
      if (dp_cmd.load) begin
         word_in = req_data_word & load_mask;
         add_in  = load_add;
         last_in = req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= 32'd0;
         total_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      add_ff  <= add_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   assign dp_status.last_item   = last_ff;
   assign dp_status.out_blocked = out_blocked;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hash_value        = out_ff;

endmodule

/* src/murmur3_32_stream_hash_top.sv */
// A word is accepted in idle; the scramble steps (SCR_A, SCR_B) and the mix step follow.
// req_stall stays high outside idle, so the next word waits until the previous one is through.
// A last word adds FIN_A, FIN_B and FIN_C; FIN_C holds while the output register is occupied.
// The next word is accepted while a finished hash waits in the output register.
// Reset (synchronous, active high) clears the running hash, byte total and output valid.
// Top level: MurmurHash3 x86_32 (seed zero) over a little-endian word stream.
module murmur3_32_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import mm3_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   mm3_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

`ifndef SYNTHESIS
   // an accepted transaction keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while previous transaction still in progress");

   // the finished hash is held back while the output register is occupied
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_FIN_C && dp_status.out_blocked) |=> dp_cmd.op == OP_FIN_C)
      else $error("finalizer result dropped while output stalled");

   // a new hash appears only from the last finalizer step
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.op) == OP_FIN_C)
      else $error("result transaction raised outside finalizer");
`endif

endmodule

/* tb/tb_murmur3_32_stream_hash_top.sv */
// Self-checking testbench for the streaming MurmurHash3 x86_32 block.
module tb_murmur3_32_stream_hash_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mm3_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned DRAIN_CYCLES   = 12;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } hash_word_type;

   typedef enum {PACE_STEADY, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_hash_value;

   hash_word_type pending_words[$];
   logic [31:0]   expected_hashes[$];
   hash_word_type offered;
   pace_type      pace = PACE_STEADY;
   logic        rsp_hold = 1'b0;
   bit          pressure_go = 1'b0;
   int unsigned words_queued = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   // running state of the predictor
   logic [31:0] run_hash = '0;
   logic [31:0] run_bytes = '0;

   murmur3_32_stream_hash_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---- hash predictor ----
   function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [31:0] scramble_word(logic [31:0] w);
      logic [31:0] t;
      t = w * SCR_MUL_A;
      t = rotl32(t, 15);
      return t * SCR_MUL_B;
   endfunction

   function automatic logic [31:0] mix_block(logic [31:0] h, logic [31:0] w);
      logic [31:0] t;
      t = rotl32(h ^ scramble_word(w), 13);
      return t * 32'd5 + ACC_ADD;
   endfunction

   function automatic logic [31:0] finalize_hash(logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * FIN_MUL_A;
      t = t ^ (t >> 13);
      t = t * FIN_MUL_B;
      return t ^ (t >> 16);
   endfunction

   // fold one accepted word into the running hash; a last word yields a hash
   task automatic fold_item(hash_word_type it);
      logic [2:0]  n;
      logic [31:0] mask;
      n = (it.byte_count > FULL_BYTES) ? FULL_BYTES : it.byte_count;
      if (!it.last) begin
         // a non-last word always counts as four bytes
         run_hash  = mix_block(run_hash, it.data_word);
         run_bytes = run_bytes + 32'd4;
      end else begin
         if (n == FULL_BYTES) begin
            run_hash = mix_block(run_hash, it.data_word);
         end else if (n != 3'd0) begin
            // tail: keep only the valid low bytes, no rotate-multiply-add
            mask     = (32'h1 << (8 * n)) - 32'h1;
            run_hash = run_hash ^ scramble_word(it.data_word & mask);
         end
         run_bytes = run_bytes + 32'(n);
         expected_hashes.push_back(finalize_hash(run_hash ^ run_bytes));
         run_hash  = '0;
         run_bytes = '0;
      end
   endtask

   // ---- pacing ----
   function automatic int unsigned send_gap_pct(pace_type p);
      case (p)
         PACE_SEND_GAPS: return 48;
         PACE_BOTH:      return 34;
         default:        return 0;
      endcase
   endfunction

   function automatic int unsigned recv_stall_pct(pace_type p);
      case (p)
         PACE_RECV_STALLS: return 48;
         PACE_BOTH:        return 34;
         default:          return 0;
      endcase
   endfunction

   // ---- driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_item(offered);
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_gap_pct(pace)) begin
               offered = pending_words.pop_front();
               req_valid      <= 1'b1;
               req_data_word  <= offered.data_word;
               req_byte_count <= offered.byte_count;
               req_last       <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- monitor and checker ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("ERROR: unexpected hash transaction %08h", rsp_hash_value);
               end
            end else begin
               logic [31:0] want;
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("ERROR: hash_value expected %08h, got %08h", want, rsp_hash_value);
                  end
               end
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99, 0) < recv_stall_pct(pace));
      end
   end

   // long receiver hold-off, counted here while the sender keeps offering
   initial begin
      wait (pressure_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL murmur3_32_stream_hash_top");
         $finish;
      end
   end

   // ---- stimulus ----
   task automatic add_word(logic [31:0] w, logic [2:0] c, logic l);
      hash_word_type it;
      it.data_word  = w;
      it.byte_count = c;
      it.last       = l;
      pending_words.push_back(it);
      words_queued++;
   endtask

   // mostly well-formed messages; a few non-last words carry odd counts
   task automatic add_random_message(int unsigned max_words);
      int unsigned n;
      logic [2:0]  c;
      n = $urandom_range(max_words, 0);
      for (int unsigned i = 0; i < n; i++) begin
         c = ($urandom_range(9, 0) == 0) ? 3'($urandom) : FULL_BYTES;
         add_word($urandom, c, 1'b0);
      end
      add_word($urandom, 3'($urandom), 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_hashes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_random_phase(pace_type p, int unsigned n_words);
      int unsigned stop_at;
      pace    = p;
      stop_at = words_queued + n_words;
      while (words_queued < stop_at) begin
         add_random_message(($urandom_range(15, 0) == 0) ? 24 : 6);
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty message, tails of every size, full last word
      add_word(32'hffffffff, 3'd0, 1'b1);
      add_word(32'hffffffff, 3'd1, 1'b1);
      add_word(32'hffffffff, 3'd2, 1'b1);
      add_word(32'h00000000, 3'd3, 1'b1);
      add_word(32'hffffffff, 3'd4, 1'b1);
      // counts above four saturate
      add_word(32'h12345678, 3'd5, 1'b1);
      add_word(32'h12345678, 3'd6, 1'b1);
      add_word(32'h12345678, 3'd7, 1'b1);
      // short counts on non-last words are taken as full words
      add_word(32'haaaaaaaa, 3'd1, 1'b0);
      add_word(32'h55555555, 3'd0, 1'b0);
      add_word(32'h00000000, 3'd7, 1'b0);
      add_word(32'hdeadbeef, 3'd2, 1'b1);
      // zero-byte last after data adds no tail
      add_word(32'h01020304, 3'd4, 1'b0);
      add_word(32'hffffffff, 3'd4, 1'b0);
      add_word(32'hcafef00d, 3'd0, 1'b1);
      // garbage above the valid tail bytes must not matter
      add_word(32'hffffff61, 3'd1, 1'b1);
      add_word(32'h00000061, 3'd1, 1'b1);
      add_word(32'h00ffffff, 3'd3, 1'b1);
      add_word(32'h00000000, 3'd4, 1'b0);
      add_word(32'h00000000, 3'd4, 1'b1);
      wait_drained();

      run_random_phase(PACE_STEADY, 180);

      // back-pressure: one-word messages pile up behind a held receiver
      pace = PACE_STEADY;
      for (int unsigned i = 0; i < 40; i++) begin
         add_word($urandom, 3'($urandom_range(4, 1)), 1'b1);
      end
      pressure_go = 1'b1;
      wait_drained();

      run_random_phase(PACE_SEND_GAPS, 200);
      run_random_phase(PACE_RECV_STALLS, 200);
      run_random_phase(PACE_BOTH, 200);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_hashes.size() == 0) begin
         $display("PASS murmur3_32_stream_hash_top");
      end else begin
         $display("FAIL murmur3_32_stream_hash_top");
      end
      $finish;
   end

endmodule
